// ===== src/lirs_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
// No dependencies; every other file in src uses this package.
package lirs_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int STEP_W        = 21;
   localparam int FRAC_BITS_DEF = 16;
   localparam int MAX_RESULTS   = 64;
   localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic [CSR_ADDR_W-3:0] REG_PHASE_STEP = '0;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       final_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       run_last;
      logic                       stream_end;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic mul;
      logic emit_interp;
      logic emit_copy;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic start_interp;
      logic start_copy;
      logic more_interp;
      logic to_copy;
      logic more_copy;
      logic out_free;
   } status_type;

endpackage

// ===== src/lirs_datapath.sv =====
// Datapath of the resampler: sample and position registers, the interpolation
// multiplier and adder, and the result register. Depends on lirs_pkg.
module lirs_datapath #(
   parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lirs_pkg::req_type              req_data,
   input  logic [lirs_pkg::STEP_W-1:0]    phase_step,
   input  lirs_pkg::cmd_type              cmd,
   output lirs_pkg::status_type           status,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output lirs_pkg::rsp_type              rsp_data
);

   localparam int SW     = lirs_pkg::SAMPLE_W;
   localparam int STW    = lirs_pkg::STEP_W;
   localparam int CW     = lirs_pkg::CNT_W;
   localparam int OFF_W  = ((FRAC_BITS + 1 > STW) ? FRAC_BITS + 1 : STW) + 1;
   localparam int PROD_W = FRAC_BITS + SW + 1;
   localparam int SUM_W  = PROD_W + 1;

   localparam logic [OFF_W-1:0] ONE_POS  = OFF_W'(1) << FRAC_BITS;
   localparam logic [STW-1:0]   MIN_STEP = STW'(1) << (FRAC_BITS - 6);
   localparam logic [SUM_W-1:0] RND_BIAS = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);
   localparam logic [CW-1:0]    CAP      = CW'(lirs_pkg::MAX_RESULTS);

   logic signed [SW-1:0]     cur_ff, prev_ff;
   logic                     fin_ff, have_prev_ff;
   logic [OFF_W-1:0]         off_ff;
   logic [CW-1:0]            cnt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     out_valid_ff;
   lirs_pkg::rsp_type        out_data_ff;

   logic [STW-1:0]           step;
   logic [OFF_W-1:0]         off_minus, off_step, step_wrap;
   logic                     off_lt_one, step_lt, wrap_lt, cnt_room;
   logic [CW-1:0]            cnt_next;
   logic signed [SW:0]       diff;
   logic signed [FRAC_BITS:0] frac_s;
   logic signed [SUM_W-1:0]  base, sum, sum_rnd;
   logic signed [SW-1:0]     interp_val;
   logic                     last_interp, last_copy;

   assign step       = (phase_step < MIN_STEP) ? MIN_STEP : phase_step;
   assign off_lt_one = off_ff < ONE_POS;
   assign off_minus  = off_ff - ONE_POS;
   assign off_step   = off_ff + OFF_W'(step);
   assign step_lt    = off_step < ONE_POS;
   assign step_wrap  = off_step - ONE_POS;
   assign wrap_lt    = step_wrap < ONE_POS;
   assign cnt_next   = cnt_ff + CW'(1);
   assign cnt_room   = cnt_next < CAP;

   always_comb begin
      status.start_interp = have_prev_ff && off_lt_one;
      status.start_copy   = fin_ff && (!have_prev_ff ||
                                       (!off_lt_one && (off_minus < ONE_POS)));
      status.more_interp  = step_lt && cnt_room;
      status.to_copy      = !(step_lt && cnt_room) && fin_ff && wrap_lt && cnt_room;
      status.more_copy    = step_lt && cnt_room;
      status.out_free     = !out_valid_ff || !rsp_stall;
   end

   assign last_interp = !status.more_interp && !status.to_copy;
   assign last_copy   = !status.more_copy;

   // prev + frac*(cur - prev), truncated toward zero
   assign diff       = (SW+1)'(cur_ff) - (SW+1)'(prev_ff);
   assign frac_s     = signed'({1'b0, off_ff[FRAC_BITS-1:0]});
   assign base       = SUM_W'(prev_ff) <<< FRAC_BITS;
   assign sum        = base + SUM_W'(prod_ff);
   assign sum_rnd    = sum + (sum[SUM_W-1] ? RND_BIAS : '0);
   assign interp_val = sum_rnd[FRAC_BITS+SW-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff <= req_data.sample_in;
         fin_ff <= req_data.final_sample;
      end
      if (cmd.mul)
         prod_ff <= PROD_W'(frac_s * diff);
      if (cmd.emit_interp) begin
         out_data_ff.sample_out <= interp_val;
         out_data_ff.run_last   <= last_interp;
         out_data_ff.stream_end <= last_interp && fin_ff;
      end else if (cmd.emit_copy) begin
         out_data_ff.sample_out <= cur_ff;
         out_data_ff.run_last   <= last_copy;
         out_data_ff.stream_end <= last_copy && fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         off_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            if (have_prev_ff) begin
               if (!off_lt_one)
                  off_ff <= off_minus;
            end else begin
               have_prev_ff <= 1'b1;
               off_ff       <= '0;
            end
         end
         if (cmd.emit_interp) begin
            off_ff <= status.more_interp ? off_step : step_wrap;
            cnt_ff <= cnt_next;
         end
         if (cmd.emit_copy) begin
            off_ff <= off_step;
            cnt_ff <= cnt_next;
         end
         if (cmd.finish) begin
            cnt_ff <= '0;
            if (fin_ff) begin
               prev_ff      <= '0;
               have_prev_ff <= 1'b0;
               off_ff       <= '0;
            end else begin
               prev_ff <= cur_ff;
            end
         end
         if (cmd.emit_interp || cmd.emit_copy)
            out_valid_ff <= 1'b1;
         else if (!rsp_stall)
            out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== src/lirs_ctrl.sv =====
// Controller state machine of the resampler: sequences accept, setup, multiply,
// interpolation, copy and wrap-up steps. Depends on lirs_pkg.
module lirs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lirs_pkg::status_type status,
   output lirs_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_INTERP = 3'd3;
   localparam logic [2:0] S_COPY   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            if (status.start_interp)
               state_in = S_MUL;
            else if (status.start_copy)
               state_in = S_COPY;
            else
               state_in = S_DONE;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_INTERP;
         end
         S_INTERP: begin
            if (status.out_free) begin
               cmd.emit_interp = 1'b1;
               if (status.more_interp)
                  state_in = S_MUL;
               else if (status.to_copy)
                  state_in = S_COPY;
               else
                  state_in = S_DONE;
            end
         end
         S_COPY: begin
            if (status.out_free) begin
               cmd.emit_copy = 1'b1;
               if (!status.more_copy)
                  state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
   end

endmodule

// ===== src/linear_interp_resampler.sv =====
// Top level of the linear interpolation resampler: APB-style register port,
// controller and datapath. Depends on lirs_pkg, lirs_ctrl and lirs_datapath.
//
// Usage:
//  - req channel: one transaction carries one signed 16-bit sample and a flag
//    marking the last sample of a stream. It is taken in when req_valid is high
//    and req_stall is low; req_stall is high while a sample is being worked on.
//  - rsp channel: each transaction is one output sample; run_last marks the
//    last one caused by a sample, stream_end the last one of a stream.
//  - Register phase_step (address 0): input/output rate ratio, unsigned with
//    FRAC_BITS fraction bits. Write it only while the block is idle.
//  - Steps per input sample: accept, setup and wrap-up, plus a multiply step
//    and then an add-and-round step per interpolated output, plus a copy step
//    per copied output at the end of a stream. The multiplier is shared by
//    all interpolated outputs and the output register is single. The first
//    interpolated result follows the setup, multiply and add-and-round steps.
//  - A stalled rsp holds the result register; the controller waits until it
//    frees and drops nothing.
//  - Reset clears the stream state and restores phase_step to 1.0.
module linear_interp_resampler #(
   parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lirs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lirs_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lirs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lirs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lirs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int STW = lirs_pkg::STEP_W;
   localparam logic [STW-1:0] STEP_RESET = STW'(1) << FRAC_BITS;

   logic [STW-1:0]       phase_step_ff;
   logic                 reg_hit;
   lirs_pkg::cmd_type    cmd;
   lirs_pkg::status_type status;

   // Register port: always ready, write on the access phase
   assign pready  = 1'b1;
   assign reg_hit = (paddr[lirs_pkg::CSR_ADDR_W-1:2] == lirs_pkg::REG_PHASE_STEP);
   assign prdata  = reg_hit ? lirs_pkg::CSR_DATA_W'(phase_step_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset)
         phase_step_ff <= STEP_RESET;
      else if (psel && penable && pwrite && pready && reg_hit)
         phase_step_ff <= pwdata[STW-1:0];
   end

   lirs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lirs_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .phase_step (phase_step_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   // An accepted transaction keeps the input closed on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after accepting a transaction");

   // Never overwrite a result that the receiver is stalling
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_interp || cmd.emit_copy) |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // The end of a stream is always the last result of its sample
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_end |-> rsp_data.run_last)
      else $error("stream_end without run_last");

   // Wrap-up returns the controller to idle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !req_stall)
      else $error("controller not idle after wrap-up");

endmodule
